[hdl/dtt_pkg.sv]
// Shared types, constants and helper functions for the dirty tile tracker.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

  // Tile grid geometry.
  localparam int TILE_SIZE = 32;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 64;

  localparam int COL_W = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

  // Pixel edge width inside the readout path, never narrower than the bounds.
  localparam int GRID_PIX = ((GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS) * TILE_SIZE;
  localparam int EDGE_W   = $clog2(GRID_PIX + 1);
  localparam int CMP_W    = (EDGE_W > 16) ? EDGE_W : 16;

  // Canvas pixel coordinates are 12 bits; tile index by reciprocal multiply.
  localparam int PIX_W      = 12;
  localparam int TILE_SH    = PIX_W + $clog2(TILE_SIZE);
  localparam int TILE_RECIP = ((2 ** TILE_SH) + TILE_SIZE - 1) / TILE_SIZE;
  localparam int PROD_W     = TILE_SH + PIX_W + 1;

  localparam logic [11:0] CANVAS_RESET = 12'd2048;

  // Configuration register indexes.
  localparam logic CFG_CANVAS_W = 1'b0;
  localparam logic CFG_CANVAS_H = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    ACT_POINT = 2'd0,
    ACT_RECT  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_MARK,
    CMD_READ,
    CMD_CLEAR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
    logic [15:0]      bw;
    logic [15:0]      bh;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MARK_RD,
    BK_MARK_WR,
    BK_READ_RD,
    BK_READ_LD,
    BK_SCAN
  } back_state_t;

  // Exact for every 12-bit pixel coordinate.
  function automatic logic [PIX_W-1:0] tile_of(input logic [PIX_W-1:0] v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(TILE_RECIP);
    return PIX_W'(p >> TILE_SH);
  endfunction

  // Index of the lowest set bit; zero when nothing is set.
  function automatic logic [COL_W-1:0] first_set(input logic [GRID_COLS-1:0] m);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = GRID_COLS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = COL_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

[hdl/dirty_tile_tracker.sv]
// Dirty tile tracker top level: front end, command queue and back end.
// A mark passes the front end's stages and the command queue; the back end's single bitmap
// port then reads and writes each tile row in turn. A read loads its row and gives one result
// per cycle while pop keeps up; a clear acts as it leaves the queue. The back end serves one
// command at a time; the front takes one transaction per cycle while full is low.
// Reset (rst_n low, synchronous) empties the map through per-row valid bits, sets both canvas
// limits to 2048 and empties the queue and the result register.
`timescale 1ns / 1ps
`default_nettype none

module dirty_tile_tracker import dtt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_rect_width,
  input  wire logic signed [15:0] in_rect_height,
  input  wire logic [5:0]         in_tile_row,
  input  wire logic [15:0]        in_bound_width,
  input  wire logic [15:0]        in_bound_height,
  output logic                    empty,
  input  wire logic               pop,
  output logic [11:0]             out_left,
  output logic [11:0]             out_top,
  output logic [11:0]             out_right,
  output logic [11:0]             out_bottom,
  output logic                    out_last,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [11:0]        cfg_data
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_din, q_dout;

  dtt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_tile_row     (in_tile_row),
    .in_bound_width  (in_bound_width),
    .in_bound_height (in_bound_height),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_din)
  );

  dtt_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  dtt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_dout),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_left   (out_left),
    .out_top    (out_top),
    .out_right  (out_right),
    .out_bottom (out_bottom),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

[hdl/dtt_front.sv]
// Front end of the dirty tile tracker: takes input transactions, clips marks
// to the canvas, turns them into tile ranges and queues commands. Uses dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_front import dtt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [1:0]         in_action,
  input  wire logic signed [15:0] in_pos_x,
  input  wire logic signed [15:0] in_pos_y,
  input  wire logic signed [15:0] in_rect_width,
  input  wire logic signed [15:0] in_rect_height,
  input  wire logic [5:0]         in_tile_row,
  input  wire logic [15:0]        in_bound_width,
  input  wire logic [15:0]        in_bound_height,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [11:0]        cfg_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output cmd_t                    q_cmd
);

  logic [11:0] cw_r, ch_r;

  // Stage 1: raw spans per axis.
  logic               s1_v_r;
  action_t            s1_act_r;
  logic [14:0]        s1_xa_r, s1_ya_r;
  logic signed [17:0] s1_ex_r, s1_ey_r;
  logic               s1_wx_r, s1_wy_r;
  logic [5:0]         s1_row_r;
  logic [15:0]        s1_bw_r, s1_bh_r;

  // Stage 2: spans clipped to the canvas.
  logic        s2_v_r;
  action_t     s2_act_r;
  logic [11:0] s2_xa_r, s2_xb_r, s2_ya_r, s2_yb_r;
  logic        s2_nex_r, s2_ney_r;
  logic [5:0]  s2_row_r;
  logic [15:0] s2_bw_r, s2_bh_r;

  logic               accept, s1_free, s2_free, s2_drop;
  action_t            in_act;
  logic               is_point;
  logic signed [17:0] ext_x, ext_y, ext_w, ext_h;
  logic signed [17:0] ex_in, ey_in;
  logic signed [17:0] lim_x, lim_y, xb, yb;
  logic               nex, ney;
  logic [11:0]        c0, c1t, c1, r0, r1t, r1;
  logic               mark_ok, row_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= CANVAS_RESET;
      ch_r <= CANVAS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_CANVAS_W) begin
        cw_r <= cfg_data;
      end else begin
        ch_r <= cfg_data;
      end
    end
  end

  assign in_act   = action_t'(in_action);
  assign is_point = (in_act == ACT_POINT);
  assign ext_x    = {{2{in_pos_x[15]}}, in_pos_x};
  assign ext_y    = {{2{in_pos_y[15]}}, in_pos_y};
  assign ext_w    = {{2{in_rect_width[15]}}, in_rect_width};
  assign ext_h    = {{2{in_rect_height[15]}}, in_rect_height};
  // A point is a one-pixel rectangle; the last covered pixel is x + w - 1.
  assign ex_in    = is_point ? ext_x : ext_x + ext_w - 18'sd1;
  assign ey_in    = is_point ? ext_y : ext_y + ext_h - 18'sd1;

  assign lim_x = $signed({6'd0, cw_r}) - 18'sd1;
  assign lim_y = $signed({6'd0, ch_r}) - 18'sd1;
  assign xb    = (s1_ex_r < lim_x) ? s1_ex_r : lim_x;
  assign yb    = (s1_ey_r < lim_y) ? s1_ey_r : lim_y;
  assign nex   = s1_wx_r && (xb >= $signed({3'd0, s1_xa_r}));
  assign ney   = s1_wy_r && (yb >= $signed({3'd0, s1_ya_r}));

  // A nonempty clipped span lies inside the 12-bit canvas.
  assign c0  = tile_of(s2_xa_r);
  assign c1t = tile_of(s2_xb_r);
  assign c1  = (c1t > 12'(GRID_COLS - 1)) ? 12'(GRID_COLS - 1) : c1t;
  assign r0  = tile_of(s2_ya_r);
  assign r1t = tile_of(s2_yb_r);
  assign r1  = (r1t > 12'(GRID_ROWS - 1)) ? 12'(GRID_ROWS - 1) : r1t;

  assign mark_ok = s2_nex_r && s2_ney_r && (c0 <= c1) && (r0 <= r1);
  assign row_in  = ({1'b0, s2_row_r} < 7'(GRID_ROWS));

  always_comb begin
    q_cmd    = '0;
    q_cmd.c0 = c0[COL_W-1:0];
    q_cmd.c1 = c1[COL_W-1:0];
    q_cmd.r0 = r0[ROW_W-1:0];
    q_cmd.r1 = r1[ROW_W-1:0];
    q_cmd.bw = s2_bw_r;
    q_cmd.bh = s2_bh_r;
    unique case (s2_act_r) inside
      ACT_POINT, ACT_RECT: begin
        q_cmd.op = CMD_MARK;
        s2_drop  = !mark_ok;
      end
      ACT_READ: begin
        q_cmd.op = CMD_READ;
        q_cmd.r0 = s2_row_r[ROW_W-1:0];
        s2_drop  = !row_in;
      end
      default: begin
        q_cmd.op = CMD_CLEAR;
        s2_drop  = 1'b0;
      end
    endcase
  end

  assign s2_free = !s2_v_r || s2_drop || !q_full;
  assign s1_free = !s1_v_r || s2_free;
  assign full    = !s1_free;
  assign accept  = push && s1_free;
  assign q_push  = s2_v_r && !s2_drop && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s2_free) begin
        s1_v_r <= 1'b0;
      end
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_act_r <= in_act;
      s1_xa_r  <= in_pos_x[15] ? 15'd0 : in_pos_x[14:0];
      s1_ya_r  <= in_pos_y[15] ? 15'd0 : in_pos_y[14:0];
      s1_ex_r  <= ex_in;
      s1_ey_r  <= ey_in;
      s1_wx_r  <= is_point || (!in_rect_width[15] && (in_rect_width != 16'sd0));
      s1_wy_r  <= is_point || (!in_rect_height[15] && (in_rect_height != 16'sd0));
      s1_row_r <= in_tile_row;
      s1_bw_r  <= in_bound_width;
      s1_bh_r  <= in_bound_height;
    end
    if (s2_free) begin
      s2_act_r <= s1_act_r;
      s2_xa_r  <= s1_xa_r[11:0];
      s2_ya_r  <= s1_ya_r[11:0];
      s2_xb_r  <= xb[11:0];
      s2_yb_r  <= yb[11:0];
      s2_nex_r <= nex;
      s2_ney_r <= ney;
      s2_row_r <= s1_row_r;
      s2_bw_r  <= s1_bw_r;
      s2_bh_r  <= s1_bh_r;
    end
  end

endmodule

`default_nettype wire

[hdl/dtt_cmdq.sv]
// Short command queue between the front end and the back end.
// Uses cmd_t and QDEPTH from dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_cmdq import dtt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  cmd_t            entry_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QA_W:0]   count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == (QA_W + 1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

[hdl/dtt_back.sv]
// Back end of the dirty tile tracker: holds the tile bitmap memory, applies
// marks and clears, and scans rows into result rectangles. Uses dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_back import dtt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       empty,
  input  wire logic  pop,
  output logic [11:0] out_left,
  output logic [11:0] out_top,
  output logic [11:0] out_right,
  output logic [11:0] out_bottom,
  output logic        out_last
);

  logic [GRID_COLS-1:0] mem [GRID_ROWS];
  logic [GRID_COLS-1:0] rd_data_r;

  back_state_t          state_r, state_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt, row_end_r, row_end_nxt;
  logic [GRID_COLS-1:0] span_r, span_nxt, mask_r, mask_nxt;
  logic [15:0]          bw_r, bw_nxt, bh_r, bh_nxt;
  logic [GRID_ROWS-1:0] valid_r, valid_nxt;
  logic                 out_v_r;
  logic [11:0]          left_r, top_r, right_r, bottom_r;
  logic                 last_r;

  logic                 mem_we, emit, slot_free;
  logic [GRID_COLS-1:0] row_word, cmd_span, mask_clr;
  logic [COL_W-1:0]     col;
  logic [CMP_W-1:0]     l, t, rt, b, rt_c, b_c, bw_x, bh_x;
  logic                 clip, none;

  // Rows never written since the last clear read as clean.
  assign row_word  = valid_r[row_r] ? rd_data_r : '0;
  assign cmd_span  = ({GRID_COLS{1'b1}} << q_cmd.c0)
                   & ({GRID_COLS{1'b1}} >> (COL_W'(GRID_COLS - 1) - q_cmd.c1));
  assign mask_clr  = mask_r & (mask_r - 1'b1);
  assign slot_free = !out_v_r || pop;

  assign col  = first_set(mask_r);
  assign l    = CMP_W'(col) * CMP_W'(TILE_SIZE);
  assign t    = CMP_W'(row_r) * CMP_W'(TILE_SIZE);
  assign rt   = l + CMP_W'(TILE_SIZE);
  assign b    = t + CMP_W'(TILE_SIZE);
  assign bw_x = CMP_W'(bw_r);
  assign bh_x = CMP_W'(bh_r);
  assign clip = (bw_r != 16'd0) && (bh_r != 16'd0);
  assign rt_c = (clip && (rt > bw_x)) ? bw_x : rt;
  assign b_c  = (clip && (b > bh_x)) ? bh_x : b;
  assign none = clip && ((l >= rt_c) || (t >= b_c));

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    row_end_nxt = row_end_r;
    span_nxt    = span_r;
    mask_nxt    = mask_r;
    bw_nxt      = bw_r;
    bh_nxt      = bh_r;
    valid_nxt   = valid_r;
    q_pop       = 1'b0;
    mem_we      = 1'b0;
    emit        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          row_nxt     = q_cmd.r0;
          row_end_nxt = q_cmd.r1;
          span_nxt    = cmd_span;
          bw_nxt      = q_cmd.bw;
          bh_nxt      = q_cmd.bh;
          unique case (q_cmd.op)
            CMD_MARK:  state_nxt = BK_MARK_RD;
            CMD_READ:  state_nxt = BK_READ_RD;
            CMD_CLEAR: valid_nxt = '0;
            default:   state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_MARK_RD: state_nxt = BK_MARK_WR;
      BK_MARK_WR: begin
        mem_we           = 1'b1;
        valid_nxt[row_r] = 1'b1;
        if (row_r == row_end_r) begin
          state_nxt = BK_IDLE;
        end else begin
          row_nxt   = row_r + 1'b1;
          state_nxt = BK_MARK_RD;
        end
      end
      BK_READ_RD: state_nxt = BK_READ_LD;
      BK_READ_LD: begin
        mask_nxt  = row_word;
        state_nxt = (row_word == '0) ? BK_IDLE : BK_SCAN;
      end
      BK_SCAN: begin
        if (slot_free) begin
          emit     = 1'b1;
          mask_nxt = mask_clr;
          if (mask_clr == '0) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      valid_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      if (emit) begin
        out_v_r <= 1'b1;
      end else if (pop) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    row_end_r <= row_end_nxt;
    span_r    <= span_nxt;
    mask_r    <= mask_nxt;
    bw_r      <= bw_nxt;
    bh_r      <= bh_nxt;
    if (emit) begin
      left_r   <= none ? 12'd0 : l[11:0];
      top_r    <= none ? 12'd0 : t[11:0];
      right_r  <= none ? 12'd0 : rt_c[11:0];
      bottom_r <= none ? 12'd0 : b_c[11:0];
      last_r   <= (mask_clr == '0);
    end
  end

  // Bitmap memory: one read-modify-write port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[row_r] <= row_word | span_r;
    end
    rd_data_r <= mem[row_r];
  end

  assign empty      = !out_v_r;
  assign out_left   = left_r;
  assign out_top    = top_r;
  assign out_right  = right_r;
  assign out_bottom = bottom_r;
  assign out_last   = last_r;

  a_scan_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SCAN) |-> (mask_r != '0))
    else $error("row scan running with no dirty tile left");

  a_mark_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_MARK_WR) |-> (row_r <= row_end_r))
    else $error("mark sweep ran past its last row");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_IDLE) && !q_empty && (q_cmd.op == CMD_CLEAR)) |=> (valid_r == '0))
    else $error("clear left rows marked valid");

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !pop) |=> ($stable(left_r) && $stable(last_r)))
    else $error("result overwritten while waiting");

endmodule

`default_nettype wire

[verif/tb_dirty_tile_tracker.sv]
// Self-checking testbench for the dirty tile tracker: directed and random requests,
// checked against an in-bench bitmap predictor. Depends on dtt_pkg and dirty_tile_tracker.
`timescale 1ns / 1ps

module tb_dirty_tile_tracker;
  import dtt_pkg::*;

  // Long enough for six full-height marks still in flight to finish.
  localparam int      SETTLE_CYCLES  = 1000;
  localparam int      MAX_REPORTS    = 10;
  localparam longint  TIMEOUT_NS     = 20_000_000;

  typedef struct {
    action_t            act;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [5:0]         row;
    logic [15:0]        bw;
    logic [15:0]        bh;
  } tile_req_t;

  typedef struct {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic        last;
  } tile_rect_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  action_t            in_action = ACT_POINT;
  logic signed [15:0] in_pos_x = '0;
  logic signed [15:0] in_pos_y = '0;
  logic signed [15:0] in_rect_width = '0;
  logic signed [15:0] in_rect_height = '0;
  logic [5:0]         in_tile_row = '0;
  logic [15:0]        in_bound_width = '0;
  logic [15:0]        in_bound_height = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [11:0]        out_left;
  logic [11:0]        out_top;
  logic [11:0]        out_right;
  logic [11:0]        out_bottom;
  logic               out_last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_CANVAS_W;
  logic [11:0]        cfg_data = '0;

  dirty_tile_tracker u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_rect_width   (in_rect_width),
    .in_rect_height  (in_rect_height),
    .in_tile_row     (in_tile_row),
    .in_bound_width  (in_bound_width),
    .in_bound_height (in_bound_height),
    .empty           (empty),
    .pop             (pop),
    .out_left        (out_left),
    .out_top         (out_top),
    .out_right       (out_right),
    .out_bottom      (out_bottom),
    .out_last        (out_last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: one dirty bit per tile and the canvas limits.
  logic [GRID_COLS-1:0] tile_map [GRID_ROWS];
  int                   canvas_w = 2048;
  int                   canvas_h = 2048;

  tile_req_t  pending_reqs[$];
  tile_rect_t expected_rects[$];
  tile_req_t  next_req;
  bit         req_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         recv_stall_left = 0;
  int         errors = 0;
  int         reported = 0;
  int         reqs_accepted = 0;
  int         reads_accepted = 0;
  int         rects_checked = 0;
  int         canvas_settings = 0;

  initial begin
    foreach (tile_map[r]) tile_map[r] = '0;
  end

  function automatic void mark_pixel(int px, int py);
    int c;
    int r;
    if (px < 0 || py < 0 || px >= canvas_w || py >= canvas_h) return;
    c = px / TILE_SIZE;
    r = py / TILE_SIZE;
    if (c >= GRID_COLS || r >= GRID_ROWS) return;
    tile_map[r][c] = 1'b1;
  endfunction

  function automatic void mark_area(int x, int y, int w, int h);
    int c0;
    int c1;
    int r0;
    int r1;
    if (w < 1 || h < 1) return;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (w > canvas_w - x) w = canvas_w - x;
    if (h > canvas_h - y) h = canvas_h - y;
    if (w < 1 || h < 1) return;
    c0 = x / TILE_SIZE;
    r0 = y / TILE_SIZE;
    // The last covered pixel is one short of x + w.
    c1 = (x + w - 1) / TILE_SIZE;
    r1 = (y + h - 1) / TILE_SIZE;
    if (c1 > GRID_COLS - 1) c1 = GRID_COLS - 1;
    if (r1 > GRID_ROWS - 1) r1 = GRID_ROWS - 1;
    if (c0 > c1 || r0 > r1) return;
    for (int r = r0; r <= r1; r++) begin
      for (int c = c0; c <= c1; c++) tile_map[r][c] = 1'b1;
    end
  endfunction

  function automatic void read_tiles(int unsigned row, int unsigned bw, int unsigned bh);
    logic [GRID_COLS-1:0] word;
    int                   n;
    int                   k;
    int unsigned          l;
    int unsigned          t;
    int unsigned          rt;
    int unsigned          b;
    tile_rect_t           e;
    if (row >= GRID_ROWS) return;
    word = tile_map[row];
    n = $countones(word);
    k = 0;
    for (int c = 0; c < GRID_COLS; c++) begin
      if (word[c]) begin
        l  = c * TILE_SIZE;
        t  = row * TILE_SIZE;
        rt = l + TILE_SIZE;
        b  = t + TILE_SIZE;
        // The bound only applies when both of its sizes are nonzero.
        if (bw != 0 && bh != 0) begin
          if (rt > bw) rt = bw;
          if (b > bh) b = bh;
          if (l >= rt || t >= b) begin
            l = 0;
            t = 0;
            rt = 0;
            b = 0;
          end
        end
        e.left   = l[11:0];
        e.top    = t[11:0];
        e.right  = rt[11:0];
        e.bottom = b[11:0];
        e.last   = (k == n - 1);
        expected_rects.insert(expected_rects.size(), e);
        k++;
      end
    end
  endfunction

  function automatic void apply_request(action_t act, int x, int y, int w, int h,
                                        int unsigned row, int unsigned bw, int unsigned bh);
    case (act)
      ACT_POINT: mark_pixel(x, y);
      ACT_RECT:  mark_area(x, y, w, h);
      ACT_READ:  read_tiles(row, bw, bh);
      default: begin
        foreach (tile_map[r]) tile_map[r] = '0;
      end
    endcase
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic void add_req(action_t act, int x, int y, int w, int h,
                                  int row, int bw, int bh);
    tile_req_t q;
    q.act = act;
    q.x   = 16'(x);
    q.y   = 16'(y);
    q.w   = 16'(w);
    q.h   = 16'(h);
    q.row = 6'(row);
    q.bw  = 16'(bw);
    q.bh  = 16'(bh);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic int rand_size();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return rand_between(-8, 200);
    if (pick < 95) return rand_between(1, 2500);
    return rand_between(-32768, 32767);
  endfunction

  function automatic tile_req_t make_random_req();
    tile_req_t q;
    int        pick;
    int        bsel;
    q.act = action_t'($urandom_range(0, 3));
    q.x   = 16'($urandom);
    q.y   = 16'($urandom);
    q.w   = 16'($urandom);
    q.h   = 16'($urandom);
    q.row = 6'($urandom);
    q.bw  = 16'($urandom);
    q.bh  = 16'($urandom);
    pick = $urandom_range(99);
    // A tenth of the traffic is raw noise across the full field ranges.
    if (pick < 10) return q;
    if (pick < 38) begin
      q.act = ACT_POINT;
      q.x   = 16'(rand_between(-40, canvas_w + 40));
      q.y   = 16'(rand_between(-40, canvas_h + 40));
    end else if (pick < 65) begin
      q.act = ACT_RECT;
      q.x   = 16'(rand_between(-200, canvas_w));
      q.y   = 16'(rand_between(-200, canvas_h));
      q.w   = 16'(rand_size());
      q.h   = 16'(rand_size());
    end else if (pick < 97) begin
      q.act = ACT_READ;
      if ($urandom_range(99) < 70) q.row = 6'(rand_between(0, (canvas_h - 1) / TILE_SIZE));
      bsel = $urandom_range(9);
      if (bsel < 5) begin
        q.bw = '0;
        q.bh = '0;
      end else if (bsel < 7) begin
        if (bsel == 5) q.bw = '0;
        else q.bh = '0;
      end else begin
        q.bw = 16'(rand_between(1, 2100));
        q.bh = 16'(rand_between(1, 2100));
      end
    end else begin
      q.act = ACT_CLEAR;
    end
    return q;
  endfunction

  // Driver: a new transaction is offered only once the previous one has gone.
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        push            <= 1'b1;
        in_action       <= next_req.act;
        in_pos_x        <= next_req.x;
        in_pos_y        <= next_req.y;
        in_rect_width   <= next_req.w;
        in_rect_height  <= next_req.h;
        in_tile_row     <= next_req.row;
        in_bound_width  <= next_req.bw;
        in_bound_height <= next_req.bh;
      end else begin
        push <= 1'b0;
      end
    end
    req_taken = 1'b0;
  end

  // Receiver: a long hold-off takes priority over the random idling.
  always @(negedge clk) begin
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: results are checked before the accepted request is predicted.
  always @(posedge clk) begin
    tile_rect_t e;
    if (rst_n) begin
      if (pop && !empty) begin
        if (expected_rects.size() == 0) begin
          errors++;
          if (reported < MAX_REPORTS) begin
            reported++;
            $display("Unexpected result: l=%0d t=%0d r=%0d b=%0d last=%0b",
                     out_left, out_top, out_right, out_bottom, out_last);
          end
        end else begin
          e = expected_rects.pop_front();
          rects_checked++;
          if (out_left !== e.left || out_top !== e.top || out_right !== e.right ||
              out_bottom !== e.bottom || out_last !== e.last) begin
            errors++;
            if (reported < MAX_REPORTS) begin
              reported++;
              $display("Mismatch: expected l=%0d t=%0d r=%0d b=%0d last=%0b,",
                       e.left, e.top, e.right, e.bottom, e.last,
                       " got l=%0d t=%0d r=%0d b=%0d last=%0b",
                       out_left, out_top, out_right, out_bottom, out_last);
            end
          end
        end
      end
      if (push && !full) begin
        apply_request(in_action, int'(in_pos_x), int'(in_pos_y), int'(in_rect_width),
                      int'(in_rect_height), in_tile_row, in_bound_width, in_bound_height);
        reqs_accepted++;
        if (in_action == ACT_READ) reads_accepted++;
        req_taken = 1'b1;
      end
    end
  end

  // Marks give no result, so after the queues drain the block may still be busy.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || push || expected_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_canvas(int w, int h);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CANVAS_W;
    cfg_data  <= 12'(w);
    @(posedge clk);
    canvas_w = w & 12'hFFF;
    @(negedge clk);
    cfg_index <= CFG_CANVAS_H;
    cfg_data  <= 12'(h);
    @(posedge clk);
    canvas_h = h & 12'hFFF;
    @(negedge clk);
    cfg_we <= 1'b0;
    canvas_settings++;
  endtask

  task automatic run_random(int send_pct, int recv_pct, int count);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) pending_reqs.insert(pending_reqs.size(), make_random_req());
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on a 2048 by 2048 canvas, which the tile grid covers exactly.
    set_canvas(2048, 2048);
    send_idle_pct = 15;
    recv_idle_pct = 61;
    add_req(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0);                 // clean row
    add_req(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
    add_req(ACT_POINT, 2047, 2047, 0, 0, 0, 0, 0);
    add_req(ACT_POINT, -1, 5, 0, 0, 0, 0, 0);               // left of the canvas
    add_req(ACT_POINT, 2048, 0, 0, 0, 0, 0, 0);             // at the width limit
    add_req(ACT_POINT, 0, -32768, 0, 0, 0, 0, 0);
    add_req(ACT_POINT, 32767, 32767, 0, 0, 0, 0, 0);
    add_req(ACT_RECT, -32768, -32768, 32767, 32767, 0, 0, 0); // empty once clipped
    add_req(ACT_RECT, 100, 100, 0, 10, 0, 0, 0);
    add_req(ACT_RECT, 100, 100, -5, 10, 0, 0, 0);
    add_req(ACT_RECT, 2000, 0, 32767, 40, 0, 0, 0);
    add_req(ACT_RECT, 31, 31, 2, 2, 0, 0, 0);
    add_req(ACT_RECT, 32, 64, 32, 32, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 0, 40, 16);               // some tiles fall outside
    add_req(ACT_READ, 0, 0, 0, 0, 63, 65535, 65535);
    add_req(ACT_READ, 0, 0, 0, 0, 1, 33, 0);                // half a bound clips nothing
    add_req(ACT_READ, 0, 0, 0, 0, 2, 0, 100);
    add_req(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 63, 0, 0);
    wait_drained();

    // One-pixel canvas: only pixel (0, 0) can be marked.
    set_canvas(1, 1);
    add_req(ACT_POINT, 1, 0, 0, 0, 0, 0, 0);
    add_req(ACT_RECT, 0, 0, 100, 100, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    add_req(ACT_READ, 0, 0, 0, 0, 1, 0, 0);
    wait_drained();

    set_canvas(rand_between(300, 2048), rand_between(300, 2048));
    run_random(15, 61, 170);

    set_canvas(2048, rand_between(1, 200));
    run_random(61, 15, 170);

    // Hold the receiver off while randomly chosen rows of a full-canvas mark are read back.
    set_canvas(rand_between(1, 2048), rand_between(64, 2048));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_req(ACT_RECT, 0, 0, 32767, 32767, 0, 0, 0);
    repeat (24) begin
      add_req(ACT_READ, 0, 0, 0, 0, rand_between(0, (canvas_h - 1) / TILE_SIZE), 0, 0);
    end
    recv_stall_left = 400;
    wait_drained();
    run_random(0, 0, 150);

    $display("Covered %0d requests (%0d row reads), %0d tile rectangles checked,",
             reqs_accepted, reads_accepted, rects_checked,
             " %0d canvas settings.", canvas_settings);
    errors += expected_rects.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d rectangles still pending", expected_rects.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
